/* rtl/asnp_pkg.sv */
// ============================================================================
// ASCII signed number parser: shared package
// Character codes, field widths and the classified character record that
// passes from the front end through the queue to the parse engine.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package asnp_pkg;

   // Field widths of the request and response payloads.
   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 32;
   localparam int LEN_W   = 6;
   localparam int DIGIT_W = 4;

   // Default saturation limit of the character count.
   localparam int MAX_LEN_DEFAULT = 63;

   // Number of classified characters held between front end and engine.
   localparam int QUEUE_DEPTH = 2;

   // ASCII codes the parser recognizes.
   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_X = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;

   // Value of the hex digit 'A'.
   localparam logic [DIGIT_W-1:0] HEX_ALPHA_BASE = 4'd10;

   // One character after classification.
   typedef struct packed {
      logic [CHAR_W-1:0]  char_code;
      logic               is_minus;
      logic               is_zero;
      logic               is_x;
      logic               is_dec;
      logic               is_hex;
      logic [DIGIT_W-1:0] digit;
   } char_entry_type;

endpackage

`default_nettype wire

/* rtl/asnp_front.sv */
// ============================================================================
// ASCII signed number parser: front end
// Accepts request characters and classifies each one into sign, prefix and
// digit flags plus its digit value, then pushes the record into the queue.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module asnp_front (
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [asnp_pkg::CHAR_W-1:0]  req_char_in,
   output logic                              push_valid,
   input  wire logic                         push_ready,
   output asnp_pkg::char_entry_type          push_entry
);

   logic [asnp_pkg::CHAR_W-1:0] dec_offset;
   logic [asnp_pkg::CHAR_W-1:0] alpha_offset;
   logic                        is_dec;
   logic                        is_alpha;

   // A request is taken whenever the queue has room.
   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   // Character classification.
   always_comb begin
      dec_offset   = req_char_in - asnp_pkg::CHAR_ZERO;
      alpha_offset = req_char_in - asnp_pkg::CHAR_UPPER_A;
      is_dec       = (req_char_in >= asnp_pkg::CHAR_ZERO) &&
                     (req_char_in <= asnp_pkg::CHAR_NINE);
      is_alpha     = (req_char_in >= asnp_pkg::CHAR_UPPER_A) &&
                     (req_char_in <= asnp_pkg::CHAR_UPPER_F);

      push_entry.char_code = req_char_in;
      push_entry.is_minus  = (req_char_in == asnp_pkg::CHAR_MINUS);
      push_entry.is_zero   = (req_char_in == asnp_pkg::CHAR_ZERO);
      push_entry.is_x      = (req_char_in == asnp_pkg::CHAR_LOWER_X);
      push_entry.is_dec    = is_dec;
      push_entry.is_hex    = is_dec || is_alpha;
      if (is_alpha) begin
         push_entry.digit = alpha_offset[asnp_pkg::DIGIT_W-1:0] + asnp_pkg::HEX_ALPHA_BASE;
      end else begin
         push_entry.digit = dec_offset[asnp_pkg::DIGIT_W-1:0];
      end
   end

endmodule

`default_nettype wire

/* rtl/asnp_queue.sv */
// ============================================================================
// ASCII signed number parser: character queue
// Small register FIFO of classified characters that decouples the request
// side from the parse engine so each side can stall on its own.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module asnp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire asnp_pkg::char_entry_type push_entry,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output asnp_pkg::char_entry_type  pop_entry
);

   localparam int DEPTH = asnp_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   asnp_pkg::char_entry_type entry_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   // Handshake on both sides.
   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_entry  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* rtl/asnp_engine.sv */
// ============================================================================
// ASCII signed number parser: parse engine
// Runs the sign, prefix, hex and decimal state machine on one classified
// character per cycle while the response slot is free or being read, and registers the response when a number ends.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module asnp_engine #(
   parameter int MaxLen = asnp_pkg::MAX_LEN_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              pop_valid,
   output logic                                   pop_ready,
   input  wire asnp_pkg::char_entry_type          pop_entry,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [asnp_pkg::VALUE_W-1:0]    rsp_value,
   output logic        [asnp_pkg::LEN_W-1:0]      rsp_consumed_len,
   output logic        [asnp_pkg::CHAR_W-1:0]     rsp_end_char,
   output logic                                   rsp_len_saturated
);

   localparam int CNT_W = $clog2(MaxLen + 1);
   localparam int EXT_W = (CNT_W > asnp_pkg::LEN_W) ? CNT_W : asnp_pkg::LEN_W;
   localparam int VW    = asnp_pkg::VALUE_W;

   // Parse modes.
   localparam logic [2:0] MODE_START = 3'd0;
   localparam logic [2:0] MODE_SIGN  = 3'd1;
   localparam logic [2:0] MODE_ZERO  = 3'd2;
   localparam logic [2:0] MODE_HEX   = 3'd3;
   localparam logic [2:0] MODE_DEC   = 3'd4;

   logic [2:0]       mode_ff, mode_in;
   logic [VW-1:0]    acc_ff, acc_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                rsp_value_ff, rsp_value_in;
   logic [asnp_pkg::LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic [asnp_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic                         rsp_sat_ff, rsp_sat_in;

   logic             step;
   logic             take;
   logic             finish;
   logic [VW-1:0]    digit_ext;
   logic [VW-1:0]    acc_hex;
   logic [VW-1:0]    acc_dec;
   logic [EXT_W-1:0] count_ext;

   // The engine moves when a character waits and the response slot is free or being read out.
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign step      = pop_valid && pop_ready;

   // Constant multiply-add for both radixes.
   assign digit_ext = VW'(pop_entry.digit);
   assign acc_hex   = {acc_ff[VW-5:0], 4'b0000} + digit_ext;
   assign acc_dec   = {acc_ff[VW-4:0], 3'b000} + {acc_ff[VW-2:0], 1'b0} + digit_ext;
   assign count_ext = EXT_W'(count_ff);

   // Parse state machine.
   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      neg_in  = neg_ff;
      take    = 1'b0;
      finish  = 1'b0;

      unique case (mode_ff)
         MODE_ZERO: begin
            if (pop_entry.is_x) begin
               mode_in = MODE_HEX;
               take    = 1'b1;
            end else if (pop_entry.is_dec) begin
               acc_in  = digit_ext;
               mode_in = MODE_DEC;
               take    = 1'b1;
            end else begin
               finish = 1'b1;
            end
         end
         MODE_HEX: begin
            if (pop_entry.is_hex) begin
               acc_in = acc_hex;
               take   = 1'b1;
            end else begin
               finish = 1'b1;
            end
         end
         MODE_DEC: begin
            if (pop_entry.is_dec) begin
               acc_in = acc_dec;
               take   = 1'b1;
            end else begin
               finish = 1'b1;
            end
         end
         default: begin
            // Start and after-sign share the digit handling; unused codes act as start.
            if ((mode_ff != MODE_SIGN) && pop_entry.is_minus) begin
               neg_in  = 1'b1;
               mode_in = MODE_SIGN;
               take    = 1'b1;
            end else if (pop_entry.is_zero) begin
               mode_in = MODE_ZERO;
               take    = 1'b1;
            end else if (pop_entry.is_dec) begin
               acc_in  = digit_ext;
               mode_in = MODE_DEC;
               take    = 1'b1;
            end else begin
               finish = 1'b1;
            end
         end
      endcase

      // Character count saturates and then flags overflow.
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (take) begin
         if (count_ff < CNT_W'(MaxLen)) begin
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end

      // A finished number returns the parser to its start state.
      if (finish) begin
         mode_in  = MODE_START;
         acc_in   = '0;
         neg_in   = 1'b0;
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   // Response slot.
   always_comb begin
      rsp_value_in = rsp_value_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (step && finish) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = neg_ff ? (VW'(0) - acc_ff) : acc_ff;
         rsp_len_in   = count_ext[asnp_pkg::LEN_W-1:0];
         rsp_char_in  = pop_entry.char_code;
         rsp_sat_in   = ovf_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_START;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            mode_ff  <= mode_in;
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
            count_ff <= count_in;
            ovf_ff   <= ovf_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload registers.
   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = $signed(rsp_value_ff);
   assign rsp_consumed_len  = rsp_len_ff;
   assign rsp_end_char      = rsp_char_ff;
   assign rsp_len_saturated = rsp_sat_ff;

endmodule

`default_nettype wire

/* rtl/ascii_signed_number_parser_core.sv */
// ============================================================================
// ASCII signed number parser core
// A response is registered in the engine's response slot when its terminating character leaves the queue.
// Throughput: one character per cycle while the queue has room and the response slot is free or being read.
// Reset clears the queue, the parse state and the response slot at once.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ascii_signed_number_parser_core #(
   parameter int MaxLen = asnp_pkg::MAX_LEN_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic        [asnp_pkg::CHAR_W-1:0] req_char_in,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [asnp_pkg::VALUE_W-1:0]    rsp_value,
   output logic        [asnp_pkg::LEN_W-1:0]      rsp_consumed_len,
   output logic        [asnp_pkg::CHAR_W-1:0]     rsp_end_char,
   output logic                                   rsp_len_saturated
);

   logic                     push_valid;
   logic                     push_ready;
   asnp_pkg::char_entry_type push_entry;
   logic                     pop_valid;
   logic                     pop_ready;
   asnp_pkg::char_entry_type pop_entry;

   // Request classification.
   asnp_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_char_in (req_char_in),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_entry  (push_entry)
   );

   // Decoupling queue.
   asnp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Parse engine and response register.
   asnp_engine #(
      .MaxLen (MaxLen)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_entry         (pop_entry),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_value         (rsp_value),
      .rsp_consumed_len  (rsp_consumed_len),
      .rsp_end_char      (rsp_end_char),
      .rsp_len_saturated (rsp_len_saturated)
   );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// ASCII signed number parser core: testbench
// Streams characters into the parser with random gaps on both channels. A
// behavioral model of the parse predicts each number as its terminating
// character is taken, and every response field is compared with the oldest
// pending prediction. Directed strings, long inputs and random numbers are run.
// ============================================================================

module testbench;

   localparam int MAX_LEN         = asnp_pkg::MAX_LEN_DEFAULT;
   localparam int MAX_GAP         = 18;
   localparam int SETTLE_CYCLES   = 6;
   localparam int STALL_LIMIT     = 1000;
   localparam int RANDOM_REQUESTS = 200;
   localparam logic [asnp_pkg::CHAR_W-1:0] CHAR_SPACE = 8'h20;

   typedef enum logic [2:0] {
      PARSE_START,
      PARSE_SIGN,
      PARSE_ZERO,
      PARSE_HEX,
      PARSE_DEC
   } parse_mode_type;

   typedef struct {
      logic signed [asnp_pkg::VALUE_W-1:0] value;
      logic [asnp_pkg::LEN_W-1:0]          consumed_len;
      logic [asnp_pkg::CHAR_W-1:0]         end_char;
      logic                                len_saturated;
   } number_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [asnp_pkg::CHAR_W-1:0]         req_char_in = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [asnp_pkg::VALUE_W-1:0] rsp_value;
   logic [asnp_pkg::LEN_W-1:0]          rsp_consumed_len;
   logic [asnp_pkg::CHAR_W-1:0]         rsp_end_char;
   logic                                rsp_len_saturated;

   // Shared run state.
   bit          throttle_on = 1'b1;
   int unsigned requests_sent = 0;
   int unsigned mismatch_count = 0;
   int unsigned numbers_checked = 0;
   int unsigned saturated_seen = 0;

   // Parse state of the prediction.
   parse_mode_type               model_mode = PARSE_START;
   logic [asnp_pkg::VALUE_W-1:0] model_acc = '0;
   logic                         model_negative = 1'b0;
   int unsigned                  model_count = 0;
   logic                         model_count_sat = 1'b0;
   number_result_type            pending_numbers[$];

   ascii_signed_number_parser_core #(
      .MaxLen(MAX_LEN)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_in      (req_char_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value        (rsp_value),
      .rsp_consumed_len (rsp_consumed_len),
      .rsp_end_char     (rsp_end_char),
      .rsp_len_saturated(rsp_len_saturated)
   );

   always #5 clock = ~clock;

   // Count one character into the number, saturating at the length limit.
   task automatic count_number_char();
      if (model_count < MAX_LEN) begin
         model_count++;
      end else begin
         model_count_sat = 1'b1;
      end
   endtask

   // Advance the predicted parse by one character and queue the number it ends.
   task automatic predict_parse_step(input logic [asnp_pkg::CHAR_W-1:0] c);
      logic                         is_dec;
      logic                         is_hex_alpha;
      logic                         ends;
      logic [asnp_pkg::VALUE_W-1:0] digit;
      number_result_type            done;
      is_dec       = (c >= asnp_pkg::CHAR_ZERO) && (c <= asnp_pkg::CHAR_NINE);
      is_hex_alpha = (c >= asnp_pkg::CHAR_UPPER_A) && (c <= asnp_pkg::CHAR_UPPER_F);
      if (is_dec) begin
         digit = asnp_pkg::VALUE_W'(c) - asnp_pkg::VALUE_W'(asnp_pkg::CHAR_ZERO);
      end else begin
         digit = asnp_pkg::VALUE_W'(c) - asnp_pkg::VALUE_W'(asnp_pkg::CHAR_UPPER_A)
                 + asnp_pkg::VALUE_W'(asnp_pkg::HEX_ALPHA_BASE);
      end
      ends = 1'b0;
      case (model_mode)
         PARSE_START, PARSE_SIGN: begin
            if (model_mode == PARSE_START && c == asnp_pkg::CHAR_MINUS) begin
               model_negative = 1'b1;
               model_mode = PARSE_SIGN;
               count_number_char();
            end else if (c == asnp_pkg::CHAR_ZERO) begin
               model_mode = PARSE_ZERO;
               count_number_char();
            end else if (is_dec) begin
               model_acc = digit;
               model_mode = PARSE_DEC;
               count_number_char();
            end else begin
               ends = 1'b1;
            end
         end
         PARSE_ZERO: begin
            if (c == asnp_pkg::CHAR_LOWER_X) begin
               model_mode = PARSE_HEX;
               count_number_char();
            end else if (is_dec) begin
               model_acc = digit;
               model_mode = PARSE_DEC;
               count_number_char();
            end else begin
               ends = 1'b1;
            end
         end
         PARSE_HEX: begin
            if (is_dec || is_hex_alpha) begin
               model_acc = (model_acc << 4) + digit;
               count_number_char();
            end else begin
               ends = 1'b1;
            end
         end
         PARSE_DEC: begin
            if (is_dec) begin
               model_acc = model_acc * 10 + digit;
               count_number_char();
            end else begin
               ends = 1'b1;
            end
         end
         default: begin
            ends = 1'b1;
         end
      endcase

      // The terminator emits the number and returns the parse to its start.
      if (ends) begin
         done.value         = model_negative ? -model_acc : model_acc;
         done.consumed_len  = model_count[asnp_pkg::LEN_W-1:0];
         done.end_char      = c;
         done.len_saturated = model_count_sat;
         pending_numbers.push_back(done);
         model_mode      = PARSE_START;
         model_acc       = '0;
         model_negative  = 1'b0;
         model_count     = 0;
         model_count_sat = 1'b0;
      end
   endtask

   // Send one character request after a random gap and predict its effect.
   task automatic send_char(input logic [asnp_pkg::CHAR_W-1:0] c);
      int unsigned gap;
      gap = throttle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_parse_step(c);
      requests_sent++;
   endtask

   task automatic send_text(input string text);
      int i;
      for (i = 0; i < text.len(); i++) begin
         send_char(text[i]);
      end
   endtask

   // Decimal digits with an optional sign, total_len characters before a space.
   task automatic send_long_number(input int unsigned total_len, input bit negative);
      int unsigned i;
      if (negative) begin
         send_char(asnp_pkg::CHAR_MINUS);
      end
      for (i = negative; i < total_len; i++) begin
         send_char(asnp_pkg::CHAR_ZERO + asnp_pkg::CHAR_W'($urandom_range(0, 9)));
      end
      send_char(CHAR_SPACE);
   endtask

   // Stop sending and let every pending number come out.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_numbers.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
   endtask

   // Boundary strings and every special case of the parse.
   task automatic test_directed_cases();
      throttle_on = 1'b1;
      send_text(",");
      send_text("-,");
      send_text("--");
      send_text("0;");
      send_text("07.");
      send_text("0-");
      send_text("0xZ");
      send_text("0x1a");
      send_text("0X");
      send_text("2147483647 ");
      send_text("-2147483648 ");
      send_text("-0x80000000 ");
      send_text("4294967297 ");
      send_text("0xFFFFFFFF/");
      send_text("9@");
      send_text("0x0123456789ABCDEFG");
      send_text("8:");
      send_char(8'h00);
      send_text("1");
      send_char(8'hFF);
      send_char(8'h80);
   endtask

   // Counts at and beyond the length limit, back to back.
   task automatic test_long_numbers();
      throttle_on = 1'b0;
      send_long_number(MAX_LEN, 1'b1);
      send_long_number(MAX_LEN, 1'b0);
      send_long_number(MAX_LEN + 1, 1'b0);
      send_long_number(MAX_LEN + 17, 1'b1);
      send_text("-0x");
      repeat (70) send_char(asnp_pkg::CHAR_UPPER_F);
      send_char(asnp_pkg::CHAR_LOWER_X);
   endtask

   // Mostly well-formed numbers with random content, plus noise characters.
   task automatic test_random_numbers();
      int unsigned first;
      int unsigned phase_end;
      int unsigned shape;
      int unsigned digits;
      logic [3:0]  nibble;
      bit          drained;
      first     = requests_sent;
      phase_end = first;
      drained   = 1'b0;
      while (requests_sent < first + RANDOM_REQUESTS) begin
         // Alternate stretches with and without idle cycles.
         if (requests_sent >= phase_end) begin
            throttle_on = ($urandom_range(0, 3) != 0);
            phase_end   = requests_sent + $urandom_range(20, 80);
         end
         if (!drained && requests_sent >= first + RANDOM_REQUESTS / 2) begin
            wait_for_results();
            drained = 1'b1;
         end
         shape = $urandom_range(0, 99);
         if (shape < 12) begin
            send_char(asnp_pkg::CHAR_W'($urandom_range(0, 255)));
         end else begin
            if ($urandom_range(0, 2) == 0) begin
               send_char(asnp_pkg::CHAR_MINUS);
            end
            digits = (shape >= 96) ? $urandom_range(40, 80) : $urandom_range(0, 10);
            if (shape < 50) begin
               send_char(asnp_pkg::CHAR_ZERO);
               send_char(asnp_pkg::CHAR_LOWER_X);
               repeat (digits) begin
                  nibble = 4'($urandom_range(0, 15));
                  if (nibble < 10) begin
                     send_char(asnp_pkg::CHAR_ZERO + nibble);
                  end else begin
                     send_char(asnp_pkg::CHAR_UPPER_A + nibble - 4'd10);
                  end
               end
            end else begin
               repeat (digits) begin
                  send_char(asnp_pkg::CHAR_ZERO + asnp_pkg::CHAR_W'($urandom_range(0, 9)));
               end
            end
            send_char(asnp_pkg::CHAR_W'($urandom_range(0, 255)));
         end
      end
   endtask

   // Response side: hold ready low for a random number of cycles per result.
   int unsigned rsp_hold = 0;
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         rsp_hold = throttle_on ? $urandom_range(0, MAX_GAP) : 0;
      end else if (rsp_valid && rsp_hold > 0) begin
         rsp_hold--;
      end
      rsp_ready <= (rsp_hold == 0);
   end

   // Compare each accepted response with the oldest predicted number.
   always @(posedge clock) begin : check_numbers
      number_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_numbers.size() == 0) begin
            report_mismatch("unpredicted response end_char", '0, rsp_end_char);
         end else begin
            want = pending_numbers.pop_front();
            numbers_checked++;
            if (want.len_saturated) begin
               saturated_seen++;
            end
            if (rsp_value !== want.value) begin
               report_mismatch("value", want.value, rsp_value);
            end
            if (rsp_consumed_len !== want.consumed_len) begin
               report_mismatch("consumed_len", want.consumed_len, rsp_consumed_len);
            end
            if (rsp_end_char !== want.end_char) begin
               report_mismatch("end_char", want.end_char, rsp_end_char);
            end
            if (rsp_len_saturated !== want.len_saturated) begin
               report_mismatch("len_saturated", want.len_saturated, rsp_len_saturated);
            end
         end
      end
   end

   // Watchdog: end the run when neither channel moves for too long.
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no request or response moved for %0d cycles.", STALL_LIMIT);
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_long_numbers();
      test_random_numbers();
      wait_for_results();
      $display("Sent %0d characters and checked %0d parsed numbers, %0d saturated.",
               requests_sent, numbers_checked, saturated_seen);
      $display("Covered signs, decimal and hex digits, empty prefixes and wraparound values.");
      if (mismatch_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
